/* hw/rtl/rtch_pkg.sv */
// ----------------------------------------------------------------------------
// rtch_pkg
// Shared types and constants of the nearest ray/triangle hit unit.
// ----------------------------------------------------------------------------
package rtch_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int EPS_W      = 17;
    localparam int MAXD_W     = 31;

    localparam logic [CFG_DATA_W-1:0] DIR_Z_RESET = 32'd65536;
    localparam logic [EPS_W-1:0]      EPS_RESET   = 17'd66;
    localparam logic [MAXD_W-1:0]     MAXD_RESET  = 31'd655353446;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X     = 3'd0,
        REG_ORIGIN_Y     = 3'd1,
        REG_ORIGIN_Z     = 3'd2,
        REG_DIR_X        = 3'd3,
        REG_DIR_Y        = 3'd4,
        REG_DIR_Z        = 3'd5,
        REG_EPSILON      = 3'd6,
        REG_MAX_DISTANCE = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by_coord;
        logic signed [31:0] bz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic               last_triangle;
    } t_tri_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_hit_out;

endpackage

/* hw/rtl/ray_triangle_closest_hit_unit.sv */
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_unit
// Nearest ray/triangle hit search over a stream of triangles.
//
// The ray origin, direction, epsilon and distance bound are written through
// the configuration port; the user must do so only while the unit is idle,
// which the unit does not enforce. Triangles enter through a queue interface:
// a triangle is taken when push is high and full is low. The front clamps
// the vertices and forms the edges, a short queue holds the prepared
// triangles, and the back tests one triangle at a time. After the cross and
// dot products a triangle that fails the determinant test stops; one that
// passes goes through the divider for t, and one whose t passes forms its
// point and distance. All 30 products use the one shared multiplier, and
// the divider retires one quotient bit per cycle over COORD_WIDTH+FRAC_BITS
// bits. Only a triangle marked last gives a result; it waits in the output
// register while empty is low until pop takes it. While it is full and not
// popped, the back holds at its next result; the queue fills and full rises.
// Reset loads the register defaults and clears the queues and the hit.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_unit #(
    parameter int COORD_WIDTH = rtch_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = rtch_pkg::FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  rtch_pkg::t_tri_in                 i_tri,
    output logic                              empty,
    input  logic                              pop,
    output rtch_pkg::t_hit_out                o_res,
    input  logic                              i_cfg_we,
    input  logic [rtch_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rtch_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int IW = 9 * CW + 1;

    logic [2:0][31:0]                  r_org;
    logic [2:0][31:0]                  r_dir;
    logic [rtch_pkg::EPS_W-1:0]        r_eps;
    logic [rtch_pkg::MAXD_W-1:0]       r_maxd;
    logic                              r_out_valid;
    rtch_pkg::t_hit_out                r_out;

    logic [IW-1:0]                     item;
    logic [2:0][CW-1:0]                org_s;
    logic [2:0][CW-1:0]                dir_s;
    logic                              q_valid;
    logic [IW-1:0]                     q_item;
    logic                              q_pop;
    logic                              res_valid;
    logic                              res_ready;
    rtch_pkg::t_hit_out                res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org  <= '0;
            r_dir  <= {rtch_pkg::DIR_Z_RESET, 32'd0, 32'd0};
            r_eps  <= rtch_pkg::EPS_RESET;
            r_maxd <= rtch_pkg::MAXD_RESET;
        end else if (i_cfg_we) begin
            case (rtch_pkg::t_reg_idx'(i_cfg_idx))
                rtch_pkg::REG_ORIGIN_X:     r_org[0] <= i_cfg_data;
                rtch_pkg::REG_ORIGIN_Y:     r_org[1] <= i_cfg_data;
                rtch_pkg::REG_ORIGIN_Z:     r_org[2] <= i_cfg_data;
                rtch_pkg::REG_DIR_X:        r_dir[0] <= i_cfg_data;
                rtch_pkg::REG_DIR_Y:        r_dir[1] <= i_cfg_data;
                rtch_pkg::REG_DIR_Z:        r_dir[2] <= i_cfg_data;
                rtch_pkg::REG_EPSILON:      r_eps    <= i_cfg_data[rtch_pkg::EPS_W-1:0];
                rtch_pkg::REG_MAX_DISTANCE: r_maxd   <= i_cfg_data[rtch_pkg::MAXD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rtch_front #(
        .CW (CW)
    ) u_front (
        .i_tri     (i_tri),
        .i_org_raw (r_org),
        .i_dir_raw (r_dir),
        .o_item    (item),
        .o_org     (org_s),
        .o_dir     (dir_s)
    );

    rtch_queue #(
        .WIDTH (IW),
        .DEPTH (rtch_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (item),
        .o_full  (full),
        .i_rd    (q_pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    rtch_back #(
        .CW (CW),
        .F  (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .i_org       (org_s),
        .i_dir       (dir_s),
        .i_eps       (r_eps),
        .i_maxd      (r_maxd),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_out_valid || pop;
    assign empty     = !r_out_valid;
    assign o_res     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

endmodule

/* hw/rtl/rtch_front.sv */
// ----------------------------------------------------------------------------
// rtch_front
// Clamps the vertices and ray registers to the coordinate range and forms
// the two triangle edges and the origin offset of an incoming triangle.
// ----------------------------------------------------------------------------
module rtch_front #(
    parameter int CW = rtch_pkg::COORD_WIDTH
) (
    input  rtch_pkg::t_tri_in    i_tri,
    input  logic [2:0][31:0]     i_org_raw,
    input  logic [2:0][31:0]     i_dir_raw,
    output logic [9*CW:0]        o_item,
    output logic [2:0][CW-1:0]   o_org,
    output logic [2:0][CW-1:0]   o_dir
);

    localparam int XW = CW + 34;
    localparam logic signed [XW-1:0] SAT_HI = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

    function automatic logic signed [CW-1:0] sat(input logic signed [XW-1:0] x);
        logic signed [CW-1:0] y;
        if (x > SAT_HI) begin
            y = SAT_HI[CW-1:0];
        end else if (x < SAT_LO) begin
            y = SAT_LO[CW-1:0];
        end else begin
            y = x[CW-1:0];
        end
        return y;
    endfunction

    logic [2:0][31:0]   a_raw;
    logic [2:0][31:0]   b_raw;
    logic [2:0][31:0]   c_raw;
    logic [2:0][CW-1:0] a_s;
    logic [2:0][CW-1:0] b_s;
    logic [2:0][CW-1:0] c_s;
    logic [2:0][CW-1:0] e1;
    logic [2:0][CW-1:0] e2;
    logic [2:0][CW-1:0] so;

    assign a_raw = {i_tri.az, i_tri.ay, i_tri.ax};
    assign b_raw = {i_tri.bz, i_tri.by_coord, i_tri.bx};
    assign c_raw = {i_tri.cz, i_tri.cy, i_tri.cx};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_s[i]   = sat(XW'($signed(a_raw[i])));
            b_s[i]   = sat(XW'($signed(b_raw[i])));
            c_s[i]   = sat(XW'($signed(c_raw[i])));
            o_org[i] = sat(XW'($signed(i_org_raw[i])));
            o_dir[i] = sat(XW'($signed(i_dir_raw[i])));
            e1[i]    = sat(XW'($signed(b_s[i])) - XW'($signed(a_s[i])));
            e2[i]    = sat(XW'($signed(c_s[i])) - XW'($signed(a_s[i])));
            so[i]    = sat(XW'($signed(o_org[i])) - XW'($signed(a_s[i])));
        end
    end

    assign o_item = {i_tri.last_triangle, so, e2, e1};

endmodule

/* hw/rtl/rtch_queue.sv */
// ----------------------------------------------------------------------------
// rtch_queue
// Small first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module rtch_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rtch_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [NW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

/* hw/rtl/rtch_back.sv */
// ----------------------------------------------------------------------------
// rtch_back
// Runs the intersection test of one triangle at a time on a shared
// multiplier and a bit-serial divider, and keeps the nearest hit.
// ----------------------------------------------------------------------------
module rtch_back #(
    parameter int CW = rtch_pkg::COORD_WIDTH,
    parameter int F  = rtch_pkg::FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  logic [9*CW:0]                i_q_item,
    output logic                         o_q_pop,
    input  logic [2:0][CW-1:0]           i_org,
    input  logic [2:0][CW-1:0]           i_dir,
    input  logic [rtch_pkg::EPS_W-1:0]   i_eps,
    input  logic [rtch_pkg::MAXD_W-1:0]  i_maxd,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output rtch_pkg::t_hit_out           o_res
);

    localparam int AW  = CW + 2;
    localparam int XW  = 2 * CW + 4;
    localparam int QW  = CW + F;
    localparam int DW  = (2 * CW + 2 > 65) ? 2 * CW + 2 : 65;
    localparam int CNW = $clog2(QW);
    localparam int MSW = 2 * rtch_pkg::MAXD_W;

    localparam logic signed [XW-1:0] SAT_HI = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;
    localparam logic [CW-1:0]        T_MAX  = {1'b0, {(CW-1){1'b1}}};

    localparam logic [3:0] G_RCE2_X = 4'd0;
    localparam logic [3:0] G_SCE1_Z = 4'd5;
    localparam logic [3:0] G_DET    = 4'd6;
    localparam logic [3:0] G_UN     = 4'd7;
    localparam logic [3:0] G_VN     = 4'd8;
    localparam logic [3:0] G_TN     = 4'd9;
    localparam logic [3:0] G_PNT_X  = 4'd10;
    localparam logic [3:0] G_PNT_Z  = 4'd12;
    localparam logic [3:0] G_SQ_X   = 4'd13;
    localparam logic [3:0] G_SQ_Z   = 4'd15;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_ACC  = 8'b0000_0100,
        ST_TEST = 8'b0000_1000,
        ST_DIV  = 8'b0001_0000,
        ST_TCHK = 8'b0010_0000,
        ST_CMP  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_back_state;

    function automatic logic signed [CW-1:0] sat(input logic signed [XW-1:0] x);
        logic signed [CW-1:0] y;
        if (x > SAT_HI) begin
            y = SAT_HI[CW-1:0];
        end else if (x < SAT_LO) begin
            y = SAT_LO[CW-1:0];
        end else begin
            y = x[CW-1:0];
        end
        return y;
    endfunction

    function automatic logic [31:0] to_port(input logic signed [CW-1:0] x);
        logic signed [XW-1:0] w;
        w = XW'(x);
        return w[31:0];
    endfunction

    t_back_state              r_state;
    t_back_state              n_state;
    logic [3:0]               r_grp;
    logic [1:0]               r_term;
    logic                     r_last;
    logic [2:0][CW-1:0]       r_e1;
    logic [2:0][CW-1:0]       r_e2;
    logic [2:0][CW-1:0]       r_s;
    logic [2:0][CW-1:0]       r_rce2;
    logic [2:0][CW-1:0]       r_sce1;
    logic [2:0][CW-1:0]       r_p;
    logic signed [CW-1:0]     r_det;
    logic signed [CW-1:0]     r_un;
    logic signed [CW-1:0]     r_vn;
    logic signed [CW-1:0]     r_tn;
    logic [CW-1:0]            r_t;
    logic signed [2*CW-1:0]   r_prod;
    logic signed [AW-1:0]     r_acc;
    logic [DW-1:0]            r_dsq;
    logic [CW-1:0]            r_dd;
    logic [CW-1:0]            r_rem;
    logic [QW-1:0]            r_num;
    logic [QW-1:0]            r_quo;
    logic [CNW-1:0]           r_cnt;
    logic [MSW-1:0]           r_maxd_sq;
    logic [63:0]              r_best;
    logic [2:0][CW-1:0]       r_bp;
    logic                     r_have;

    logic [1:0]               comp;
    logic [1:0]               nxt_c;
    logic [1:0]               prv_c;
    logic                     is_cross;
    logic                     is_dot;
    logic                     is_pnt;
    logic [2:0][CW-1:0]       va;
    logic [2:0][CW-1:0]       vb;
    logic [2:0][CW-1:0]       diff;
    logic [1:0]               ka;
    logic [1:0]               kb;
    logic signed [CW-1:0]     op_a;
    logic signed [CW-1:0]     op_b;
    logic signed [XW-1:0]     prod_sh;
    logic signed [CW-1:0]     fm;
    logic signed [AW-1:0]     base;
    logic signed [AW-1:0]     acc_nxt;
    logic signed [CW-1:0]     res;
    logic                     last_term;

    logic                     neg;
    logic signed [CW:0]       det_n;
    logic signed [CW:0]       un_n;
    logic signed [CW:0]       vn_n;
    logic signed [CW:0]       tn_n;
    logic signed [CW+1:0]     uv_sum;
    logic [XW-1:0]            det_u;
    logic [XW-1:0]            eps_u;
    logic                     pass;

    logic [CW-1:0]            rem_sh;
    logic                     rem_ge;
    logic [CW-1:0]            t_val;
    logic                     t_ok;

    logic [63:0]              dsq_c;
    logic [63:0]              best_c;

    always_comb begin
        case (r_grp)
            4'd1, 4'd4, 4'd11, 4'd14: comp = 2'd1;
            4'd2, 4'd5, 4'd12, 4'd15: comp = 2'd2;
            default:                  comp = 2'd0;
        endcase
    end

    assign nxt_c    = (comp == 2'd2) ? 2'd0 : comp + 2'd1;
    assign prv_c    = (comp == 2'd0) ? 2'd2 : comp - 2'd1;
    assign is_cross = (r_grp <= G_SCE1_Z);
    assign is_dot   = (r_grp >= G_DET) && (r_grp <= G_TN);
    assign is_pnt   = (r_grp >= G_PNT_X) && (r_grp <= G_PNT_Z);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = sat(XW'($signed(r_p[i])) - XW'($signed(i_org[i])));
        end
    end

    always_comb begin
        if (r_grp < 4'd3) begin
            va = i_dir;
            vb = r_e2;
        end else if (is_cross) begin
            va = r_s;
            vb = r_e1;
        end else if (r_grp == G_DET) begin
            va = r_e1;
            vb = r_rce2;
        end else if (r_grp == G_UN) begin
            va = r_s;
            vb = r_rce2;
        end else if (r_grp == G_VN) begin
            va = i_dir;
            vb = r_sce1;
        end else if (r_grp == G_TN) begin
            va = r_e2;
            vb = r_sce1;
        end else if (is_pnt) begin
            va = i_dir;
            vb = {r_t, r_t, r_t};
        end else begin
            va = diff;
            vb = diff;
        end
    end

    always_comb begin
        if (is_cross) begin
            ka = (r_term == 2'd0) ? nxt_c : prv_c;
            kb = (r_term == 2'd0) ? prv_c : nxt_c;
        end else if (is_dot) begin
            ka = r_term;
            kb = r_term;
        end else begin
            ka = comp;
            kb = comp;
        end
    end

    assign op_a    = $signed(va[ka]);
    assign op_b    = $signed(vb[kb]);
    assign prod_sh = XW'(r_prod) >>> F;
    assign fm      = sat(prod_sh);
    assign base    = (r_term != 2'd0) ? r_acc :
                     (is_pnt ? AW'($signed(i_org[comp])) : '0);
    assign acc_nxt = (is_cross && r_term == 2'd1) ? base - AW'(fm) : base + AW'(fm);
    assign res     = sat(XW'(acc_nxt));
    assign last_term = is_cross ? (r_term == 2'd1) :
                       (is_dot ? (r_term == 2'd2) : 1'b1);

    assign neg    = r_det[CW-1];
    assign det_n  = neg ? -(CW+1)'(r_det) : (CW+1)'(r_det);
    assign un_n   = neg ? -(CW+1)'(r_un)  : (CW+1)'(r_un);
    assign vn_n   = neg ? -(CW+1)'(r_vn)  : (CW+1)'(r_vn);
    assign tn_n   = neg ? -(CW+1)'(r_tn)  : (CW+1)'(r_tn);
    assign uv_sum = (CW+2)'(un_n) + (CW+2)'(vn_n);
    assign det_u  = XW'(det_n);
    assign eps_u  = XW'(i_eps);
    assign pass   = (det_n != '0) && (det_u >= eps_u) && !un_n[CW] && (un_n <= det_n)
                    && !vn_n[CW] && (uv_sum <= (CW+2)'(det_n))
                    && !tn_n[CW] && (tn_n != '0);

    assign rem_sh = {r_rem[CW-2:0], r_num[QW-1]};
    assign rem_ge = (rem_sh >= r_dd);
    assign t_val  = (r_quo > QW'(T_MAX)) ? T_MAX : r_quo[CW-1:0];
    assign t_ok   = (XW'(t_val) > eps_u);

    assign dsq_c  = (|r_dsq[DW-1:64]) ? '1 : r_dsq[63:0];
    assign best_c = r_have ? r_best : 64'(r_maxd_sq);

    assign o_q_pop     = (r_state == ST_IDLE) && i_q_valid;
    assign o_res_valid = (r_state == ST_DONE) && r_last;

    always_comb begin
        o_res.hit     = r_have;
        o_res.point_x = r_have ? to_port($signed(r_bp[0])) : '0;
        o_res.point_y = r_have ? to_port($signed(r_bp[1])) : '0;
        o_res.point_z = r_have ? to_port($signed(r_bp[2])) : '0;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (!last_term) begin
                    n_state = ST_MUL;
                end else if (r_grp == G_TN) begin
                    n_state = ST_TEST;
                end else if (r_grp == G_SQ_Z) begin
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_TEST: begin
                n_state = pass ? ST_DIV : ST_DONE;
            end
            ST_DIV: begin
                if (r_cnt == CNW'(QW - 1)) begin
                    n_state = ST_TCHK;
                end
            end
            ST_TCHK: begin
                n_state = t_ok ? ST_MUL : ST_DONE;
            end
            ST_CMP: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_last || i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CMP && dsq_c < best_c) begin
                r_have <= 1'b1;
            end else if (o_res_valid && i_res_ready) begin
                r_have <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_maxd_sq <= MSW'(i_maxd) * MSW'(i_maxd);
        case (r_state)
            ST_IDLE: begin
                r_e1   <= i_q_item[3*CW-1:0];
                r_e2   <= i_q_item[6*CW-1:3*CW];
                r_s    <= i_q_item[9*CW-1:6*CW];
                r_last <= i_q_item[9*CW];
                r_grp  <= G_RCE2_X;
                r_term <= 2'd0;
            end
            ST_MUL: begin
                r_prod <= op_a * op_b;
            end
            ST_ACC: begin
                r_acc <= acc_nxt;
                if (r_grp >= G_SQ_X) begin
                    r_dsq <= ((r_grp == G_SQ_X) ? '0 : r_dsq) + DW'($unsigned(r_prod));
                end
                if (!last_term) begin
                    r_term <= r_term + 2'd1;
                end else begin
                    r_term <= 2'd0;
                    r_grp  <= r_grp + 4'd1;
                    if (r_grp < 4'd3) begin
                        r_rce2[comp] <= res;
                    end else if (is_cross) begin
                        r_sce1[comp] <= res;
                    end else if (r_grp == G_DET) begin
                        r_det <= res;
                    end else if (r_grp == G_UN) begin
                        r_un <= res;
                    end else if (r_grp == G_VN) begin
                        r_vn <= res;
                    end else if (r_grp == G_TN) begin
                        r_tn <= res;
                    end else if (is_pnt) begin
                        r_p[comp] <= res;
                    end
                end
            end
            ST_TEST: begin
                r_dd  <= det_n[CW-1:0];
                r_num <= {tn_n[CW-1:0], {F{1'b0}}};
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rem <= rem_ge ? rem_sh - r_dd : rem_sh;
                r_num <= {r_num[QW-2:0], 1'b0};
                r_quo <= {r_quo[QW-2:0], rem_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_TCHK: begin
                r_t    <= t_val;
                r_grp  <= G_PNT_X;
                r_term <= 2'd0;
            end
            ST_CMP: begin
                if (dsq_c < best_c) begin
                    r_best <= dsq_c;
                    r_bp   <= r_p;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* sim/ray_triangle_closest_hit_checker.sv */
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_checker
// Watches the triangle, hit and configuration ports of the nearest-hit unit.
//
// Every accepted triangle beat is run through a fixed-point Moller-Trumbore
// test kept here, against a local copy of the ray registers. A triangle
// marked last queues the expected hit beat. Every popped hit beat is compared
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    input  logic                                 full,
    input  rtch_pkg::t_tri_in                    i_tri,
    input  logic                                 empty,
    input  logic                                 pop,
    input  rtch_pkg::t_hit_out                   o_res,
    input  logic                                 i_cfg_we,
    input  logic [rtch_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rtch_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    longint                 ray_org[3];
    longint                 ray_dir[3];
    longint                 eps_q;
    longint                 bound_q;
    bit [63:0]              near_sq;
    longint                 near_pt[3];
    bit                     near_valid;
    rtch_pkg::t_hit_out     hits_due[$];

    function automatic longint clamp32(longint x);
        if (x > SMAX) return SMAX;
        if (x < SMIN) return SMIN;
        return x;
    endfunction

    function automatic longint qmul(longint a, longint b);
        logic signed [127:0] p;
        p = a;
        p = p * b;
        p = p >>> rtch_pkg::FRAC_BITS;
        if (p > 128'sd2147483647) return SMAX;
        if (p < -128'sd2147483648) return SMIN;
        return longint'(p);
    endfunction

    function automatic longint dot3(longint p[3], longint q[3]);
        return clamp32(qmul(p[0], q[0]) + qmul(p[1], q[1]) + qmul(p[2], q[2]));
    endfunction

    function automatic void xprod(input longint p[3], input longint q[3],
                                  output longint r[3]);
        r[0] = clamp32(qmul(p[1], q[2]) - qmul(p[2], q[1]));
        r[1] = clamp32(qmul(p[2], q[0]) - qmul(p[0], q[2]));
        r[2] = clamp32(qmul(p[0], q[1]) - qmul(p[1], q[0]));
    endfunction

    function automatic void clear_nearest();
        near_sq    = 64'(bound_q) * 64'(bound_q);
        near_pt    = '{0, 0, 0};
        near_valid = 1'b0;
    endfunction

    function automatic void write_reg(logic [rtch_pkg::CFG_IDX_W-1:0] idx,
                                      logic [rtch_pkg::CFG_DATA_W-1:0] data);
        case (rtch_pkg::t_reg_idx'(idx))
            rtch_pkg::REG_ORIGIN_X: ray_org[0] = longint'(signed'(data));
            rtch_pkg::REG_ORIGIN_Y: ray_org[1] = longint'(signed'(data));
            rtch_pkg::REG_ORIGIN_Z: ray_org[2] = longint'(signed'(data));
            rtch_pkg::REG_DIR_X:    ray_dir[0] = longint'(signed'(data));
            rtch_pkg::REG_DIR_Y:    ray_dir[1] = longint'(signed'(data));
            rtch_pkg::REG_DIR_Z:    ray_dir[2] = longint'(signed'(data));
            rtch_pkg::REG_EPSILON:  eps_q = longint'(data[rtch_pkg::EPS_W-1:0]);
            rtch_pkg::REG_MAX_DISTANCE: begin
                bound_q = longint'(data[rtch_pkg::MAXD_W-1:0]);
                if (!near_valid) near_sq = 64'(bound_q) * 64'(bound_q);
            end
            default: ;
        endcase
    endfunction

    function automatic void test_triangle(rtch_pkg::t_tri_in tr);
        longint    va[3], vb[3], vc[3], e1[3], e2[3], sv[3], de2[3], se1[3], pt[3];
        longint    det, un, vn, tn, tq, diff;
        bit [63:0] dsq;
        rtch_pkg::t_hit_out res;
        va = '{tr.ax, tr.ay, tr.az};
        vb = '{tr.bx, tr.by_coord, tr.bz};
        vc = '{tr.cx, tr.cy, tr.cz};
        dsq = '0;
        for (int i = 0; i < 3; i++) begin
            e1[i] = clamp32(vb[i] - va[i]);
            e2[i] = clamp32(vc[i] - va[i]);
            sv[i] = clamp32(ray_org[i] - va[i]);
        end
        xprod(ray_dir, e2, de2);
        xprod(sv, e1, se1);
        det = dot3(e1, de2);
        un  = dot3(sv, de2);
        vn  = dot3(ray_dir, se1);
        tn  = dot3(e2, se1);
        if (det < 0) begin
            det = -det;
            un  = -un;
            vn  = -vn;
            tn  = -tn;
        end
        if (det != 0 && det >= eps_q && un >= 0 && un <= det && vn >= 0
                && un + vn <= det && tn > 0) begin
            if (tn / det > (SMAX >>> rtch_pkg::FRAC_BITS)) tq = SMAX;
            else tq = (tn <<< rtch_pkg::FRAC_BITS) / det;
            if (tq > eps_q) begin
                for (int i = 0; i < 3; i++) begin
                    pt[i] = clamp32(ray_org[i] + qmul(ray_dir[i], tq));
                    diff  = clamp32(pt[i] - ray_org[i]);
                    dsq   = dsq + 64'(diff * diff);
                end
                if (dsq < near_sq) begin
                    near_sq    = dsq;
                    near_pt    = pt;
                    near_valid = 1'b1;
                end
            end
        end
        if (tr.last_triangle) begin
            res.hit     = near_valid;
            res.point_x = 32'(near_pt[0]);
            res.point_y = 32'(near_pt[1]);
            res.point_z = 32'(near_pt[2]);
            hits_due.push_back(res);
            clear_nearest();
        end
    endfunction

    always @(posedge i_clk) begin
        rtch_pkg::t_hit_out want;
        if (!i_rst_n) begin
            ray_org = '{0, 0, 0};
            ray_dir = '{0, 0, longint'(rtch_pkg::DIR_Z_RESET)};
            eps_q   = longint'(rtch_pkg::EPS_RESET);
            bound_q = longint'(rtch_pkg::MAXD_RESET);
            clear_nearest();
            hits_due.delete();
        end else begin
            if (pop && !empty) begin
                if (hits_due.size() == 0) begin
                    $error("hit beat with nothing expected");
                    o_fail_count++;
                end else begin
                    want = hits_due.pop_front();
                    if (o_res.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_res.hit);
                        o_fail_count++;
                    end
                    if (o_res.point_x !== want.point_x) begin
                        $error("point_x: expected %0d, got %0d", want.point_x,
                               o_res.point_x);
                        o_fail_count++;
                    end
                    if (o_res.point_y !== want.point_y) begin
                        $error("point_y: expected %0d, got %0d", want.point_y,
                               o_res.point_y);
                        o_fail_count++;
                    end
                    if (o_res.point_z !== want.point_z) begin
                        $error("point_z: expected %0d, got %0d", want.point_z,
                               o_res.point_z);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) write_reg(i_cfg_idx, i_cfg_data);
            if (push && !full) test_triangle(i_tri);
        end
        o_pending = hits_due.size();
    end

endmodule

/* sim/tb_ray_triangle_closest_hit_unit.sv */
// ----------------------------------------------------------------------------
// tb_ray_triangle_closest_hit_unit
// Regression of the nearest ray/triangle hit unit.
//
// Drives a directed set of triangles and then randomized meshes under
// several ray settings, most triangles built around a point on the ray so
// that they hit. Both queue sides idle at random. The checker beside the
// unit predicts and compares every hit beat.
// ----------------------------------------------------------------------------
module tb_ray_triangle_closest_hit_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE = 65536;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  push;
    logic                                  full;
    rtch_pkg::t_tri_in                     i_tri;
    logic                                  empty;
    logic                                  pop;
    rtch_pkg::t_hit_out                    o_res;
    logic                                  i_cfg_we;
    logic [rtch_pkg::CFG_IDX_W-1:0]        i_cfg_idx;
    logic [rtch_pkg::CFG_DATA_W-1:0]       i_cfg_data;
    int                                    fail_count;
    int                                    pending;
    bit                                    rx_hold;
    longint                                cur_org[3];
    longint                                cur_dir[3];
    rtch_pkg::t_tri_in                     prev_tri;

    ray_triangle_closest_hit_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_tri      (i_tri),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ray_triangle_closest_hit_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_tri        (i_tri),
        .empty        (empty),
        .pop          (pop),
        .o_res        (o_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #40_000_000;
        $display("ray_triangle_closest_hit_unit regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        int r;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (rx_hold) begin
            pop <= 1'b0;
            repeat (3000) @(posedge i_clk);
            rx_hold = 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 60)) @(posedge i_clk);
            end else if (r < 95) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                pop <= 1'b0;
                repeat ($urandom_range(50, 400)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [31:0] to32(longint x);
        if (x > 64'sd2147483647) return 32'h7fff_ffff;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return 32'(x);
    endfunction

    function automatic longint srand(int bits);
        return longint'($urandom_range(0, (1 << bits) - 1)) - (longint'(1) << (bits - 1));
    endfunction

    function automatic rtch_pkg::t_tri_in plane_tri(longint x0, longint z, bit swap,
                                                    bit last);
        rtch_pkg::t_tri_in tr;
        tr.ax = to32(x0 - ONE);
        tr.ay = to32(-ONE);
        tr.az = to32(z);
        tr.bx = to32(x0 + 2 * ONE);
        tr.by_coord = to32(-ONE);
        tr.bz = to32(z);
        tr.cx = to32(x0 - ONE);
        tr.cy = to32(2 * ONE);
        tr.cz = to32(z);
        if (swap) begin
            tr.bx = tr.cx;
            tr.by_coord = tr.cy;
            tr.cx = to32(x0 + 2 * ONE);
            tr.cy = to32(-ONE);
        end
        tr.last_triangle = last;
        return tr;
    endfunction

    function automatic rtch_pkg::t_tri_in aimed_tri(bit last);
        rtch_pkg::t_tri_in tr;
        longint  tt, cen[3], p[3], q[3], a[3];
        tt = longint'($urandom_range(1 << 13, 1 << 20));
        if ($urandom_range(0, 7) == 0) tt = -tt;
        for (int i = 0; i < 3; i++) begin
            cen[i] = cur_org[i] + ((cur_dir[i] * tt) >>> 16);
            p[i] = srand(19);
            q[i] = srand(19);
            a[i] = cen[i] - (p[i] + q[i]) / 3;
        end
        tr.ax = to32(a[0]);
        tr.ay = to32(a[1]);
        tr.az = to32(a[2]);
        tr.bx = to32(a[0] + p[0]);
        tr.by_coord = to32(a[1] + p[1]);
        tr.bz = to32(a[2] + p[2]);
        tr.cx = to32(a[0] + q[0]);
        tr.cy = to32(a[1] + q[1]);
        tr.cz = to32(a[2] + q[2]);
        tr.last_triangle = last;
        return tr;
    endfunction

    function automatic rtch_pkg::t_tri_in random_tri(bit last);
        rtch_pkg::t_tri_in tr;
        int      r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            tr = aimed_tri(last);
        end else if (r < 8) begin
            tr = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, last};
        end else if (r < 9) begin
            tr = {to32(cur_org[0] + srand(21)), to32(cur_org[1] + srand(21)),
                  to32(cur_org[2] + srand(21)), to32(cur_org[0] + srand(21)),
                  to32(cur_org[1] + srand(21)), to32(cur_org[2] + srand(21)),
                  to32(cur_org[0] + srand(21)), to32(cur_org[1] + srand(21)),
                  to32(cur_org[2] + srand(21)), last};
        end else begin
            tr = prev_tri;
            tr.last_triangle = last;
        end
        return tr;
    endfunction

    task automatic send_tri(rtch_pkg::t_tri_in tr);
        int r;
        push  <= 1'b1;
        i_tri <= tr;
        do @(posedge i_clk); while (full !== 1'b0);
        prev_tri = tr;
        r = $urandom_range(0, 99);
        if (r >= 55) begin
            push <= 1'b0;
            if (r < 90) repeat ($urandom_range(1, 4)) @(posedge i_clk);
            else if (r < 98) repeat ($urandom_range(5, 20)) @(posedge i_clk);
            else repeat ($urandom_range(50, 150)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(rtch_pkg::t_reg_idx idx, longint val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 32'(val);
        @(posedge i_clk);
    endtask

    task automatic set_ray(longint o[3], longint d[3], longint eps, longint bound);
        cur_org = o;
        cur_dir = d;
        write_reg(rtch_pkg::REG_ORIGIN_X, o[0]);
        write_reg(rtch_pkg::REG_ORIGIN_Y, o[1]);
        write_reg(rtch_pkg::REG_ORIGIN_Z, o[2]);
        write_reg(rtch_pkg::REG_DIR_X, d[0]);
        write_reg(rtch_pkg::REG_DIR_Y, d[1]);
        write_reg(rtch_pkg::REG_DIR_Z, d[2]);
        write_reg(rtch_pkg::REG_EPSILON, eps);
        write_reg(rtch_pkg::REG_MAX_DISTANCE, bound);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        longint  o[3], d[3], eps, bound;
        rtch_pkg::t_tri_in tr;
        push       <= 1'b0;
        i_tri      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        i_rst_n    <= 1'b0;
        rx_hold     = 1'b0;
        cur_org     = '{0, 0, 0};
        cur_dir     = '{0, 0, ONE};
        prev_tri    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_tri(plane_tri(0, 5 * ONE, 1'b0, 1'b0));
        send_tri(plane_tri(0, 3 * ONE, 1'b0, 1'b0));
        send_tri(plane_tri(0, 3 * ONE, 1'b1, 1'b0));
        send_tri(plane_tri(0, -2 * ONE, 1'b0, 1'b0));
        send_tri(plane_tri(5 * ONE, ONE, 1'b0, 1'b0));
        tr = plane_tri(0, ONE, 1'b0, 1'b0);
        tr.bx = tr.ax;
        tr.by_coord = tr.ay;
        tr.cx = tr.ax;
        tr.cy = tr.ay;
        send_tri(tr);
        send_tri({{9{32'h7fff_ffff}}, 1'b0});
        send_tri({{9{32'h8000_0000}}, 1'b1});
        tr.last_triangle = 1'b1;
        send_tri(tr);
        send_tri(plane_tri(0, 6 * ONE, 1'b1, 1'b1));
        send_tri(plane_tri(0, 4 * ONE, 1'b0, 1'b0));
        drain();
        write_reg(rtch_pkg::REG_MAX_DISTANCE, 2 * ONE);
        i_cfg_we <= 1'b0;
        send_tri(plane_tri(0, 7 * ONE, 1'b0, 1'b1));
        send_tri(plane_tri(0, ONE, 1'b0, 1'b0));
        send_tri(plane_tri(0, 3 * ONE, 1'b0, 1'b1));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            for (int i = 0; i < 3; i++) begin
                o[i] = srand(23);
                d[i] = srand(18);
            end
            eps   = $urandom_range(0, 2000);
            bound = $urandom_range(1 << 20, 32'h7fff_ffff);
            case (ph)
                0: begin
                    eps   = 0;
                    bound = 32'h7fff_ffff;
                end
                1: eps = ONE;
                2: bound = 0;
                3: begin
                    o = '{32'h7fff_ffff, -64'sd2147483648, 32'h7fff_ffff};
                    d = '{-64'sd2147483648, 32'h7fff_ffff, 0};
                end
                4: d = '{0, 0, 0};
                default: ;
            endcase
            set_ray(o, d, eps, bound);
            for (int n = 0; n < 140; n++) begin
                if (ph == 5 && n == 20) rx_hold = 1'b1;
                send_tri(random_tri(n == 139 || $urandom_range(0, 5) == 0));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("ray_triangle_closest_hit_unit regression: pass");
        end else begin
            $display("ray_triangle_closest_hit_unit regression: fail");
        end
        $finish;
    end

endmodule
